// File: hdl/swre_pkg.sv
// shared types, constants and helpers for the window rank engine
`default_nettype none
package swre_pkg;

  localparam int PARTITION_MAX_DEF     = 65536;
  localparam int PEER_BUFFER_DEPTH_DEF = 32;

  localparam int POS_W  = 16;
  localparam int KEY_W  = 64;
  localparam int SIZE_W = 17;
  localparam int VAL_W  = 33;
  localparam int QUO_W  = 32;

  // function_mode codes
  localparam logic [2:0] MODE_ROW_NUMBER = 3'd0;
  localparam logic [2:0] MODE_RANK       = 3'd1;
  localparam logic [2:0] MODE_DENSE_RANK = 3'd2;
  localparam logic [2:0] MODE_PCT_RANK   = 3'd3;
  localparam logic [2:0] MODE_CUME_DIST  = 3'd4;
  localparam logic [2:0] MODE_NTILE      = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_FUNCTION_MODE    = 2'd0;
  localparam logic [1:0] CFG_NTILE_BUCKETS    = 2'd1;
  localparam logic [1:0] CFG_NULLS_SORT_FIRST = 2'd2;
  localparam logic [1:0] CFG_NULL_KEY_VALUE   = 2'd3;

  localparam logic [VAL_W-1:0] ONE_Q32 = {1'b1, {QUO_W{1'b0}}};

  typedef struct packed {
    logic              start;
    logic              frac;
    logic [SIZE_W:0]   num;
    logic [SIZE_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QUO_W-1:0] quot;
  } div_rsp_t;

  // strict ordering with null sentinel handling
  function automatic logic key_before(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b,
                                      input logic [KEY_W-1:0] null_key, input logic nfirst);
    logic an;
    logic bn;
    an = (a == null_key);
    bn = (b == null_key);
    if (an && bn) return 1'b0;
    if (an) return nfirst;
    if (bn) return !nfirst;
    return $signed(a) < $signed(b);
  endfunction

endpackage
`default_nettype wire

// File: hdl/swre_ram.sv
// generic single-port-write ram with registered read
`default_nettype none
module swre_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// File: hdl/swre_div.sv
// restoring divider, one quotient bit per cycle, integer or q32 fraction
`default_nettype none
module swre_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire swre_pkg::div_req_t req,
  output swre_pkg::div_rsp_t      rsp
);
  import swre_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic [SIZE_W:0]   rem_r, rem_nxt;
  logic [QUO_W-1:0]  dvd_r, dvd_nxt;
  logic [QUO_W-1:0]  quot_r, quot_nxt;
  logic [SIZE_W-1:0] den_r, den_nxt;
  logic [SIZE_W:0]   trial;
  logic              ge;

  assign trial = {rem_r[SIZE_W-1:0], dvd_r[QUO_W-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    quot_nxt = quot_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      den_nxt  = req.den;
      quot_nxt = '0;
      if (req.frac) begin
        // remainder starts at the numerator, zeros shift in
        cnt_nxt = 6'd32;
        rem_nxt = req.num;
        dvd_nxt = '0;
      end else begin
        cnt_nxt = 6'd18;
        rem_nxt = '0;
        dvd_nxt = {req.num, {(QUO_W-SIZE_W-1){1'b0}}};
      end
    end else if (busy_r) begin
      rem_nxt  = ge ? trial - {1'b0, den_r} : trial;
      dvd_nxt  = {dvd_r[QUO_W-2:0], 1'b0};
      quot_nxt = {quot_r[QUO_W-2:0], ge};
      cnt_nxt  = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    quot_r <= quot_nxt;
    den_r  <= den_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
endmodule
`default_nettype wire

// File: hdl/sql_window_rank_engine.sv
// SQL window ranking engine: row number, rank, dense rank, percent rank, cume dist, ntile
//
// One item is one sorted row of a partition; the block takes one item at a time and
// in_tready is high only while the sequencer is idle. Percent rank and ntile use the
// shared restoring divider (32 steps for a q32 fraction, 18 for an integer quotient);
// a percent rank of zero or one needs no divide. Cume dist buffers a row while there
// is room. When a peer group closes it runs the divider (skipped when the fraction
// saturates at one), then reads each buffered row from ram and loads it into the
// output register. Output stalls hold the sequencer only while a new result has to
// be loaded into the output register.
// The output register lets the next item be accepted while a result waits to be taken.
`default_nettype none
module sql_window_rank_engine #(
  parameter int PARTITION_MAX     = swre_pkg::PARTITION_MAX_DEF,
  parameter int PEER_BUFFER_DEPTH = swre_pkg::PEER_BUFFER_DEPTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [63:0]  cfg_wdata,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [103:0] in_tdata,   // row_position, order_key, part_rows
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [55:0]       out_tdata,  // out_position, window_value, group_overflow
  output logic              out_tlast
);
  import swre_pkg::*;

  localparam int AW    = PEER_BUFFER_DEPTH > 1 ? $clog2(PEER_BUFFER_DEPTH) : 1;
  localparam int PCW   = $clog2(PEER_BUFFER_DEPTH + 1);
  localparam int PMAX  = PARTITION_MAX > 131071 ? 131071 : PARTITION_MAX;
  localparam logic [SIZE_W-1:0] PMAX_S = SIZE_W'(PMAX);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_PUT  = 9'b000000010,
    S_NT1  = 9'b000000100,
    S_DIV  = 9'b000001000,
    S_C1   = 9'b000010000,
    S_C2   = 9'b000100000,
    S_C3   = 9'b001000000,
    S_FRD  = 9'b010000000,
    S_FOUT = 9'b100000000
  } state_t;

  // configuration
  logic [2:0]        mode_r;
  logic [SIZE_W-1:0] nbk_r;
  logic              nfirst_r;
  logic [KEY_W-1:0]  nullkey_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_ROW_NUMBER;
      nbk_r     <= SIZE_W'(1);
      nfirst_r  <= 1'b0;
      nullkey_r <= {1'b1, {(KEY_W-1){1'b0}}};
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FUNCTION_MODE:    mode_r    <= cfg_wdata[2:0];
        CFG_NTILE_BUCKETS:    nbk_r     <= cfg_wdata[SIZE_W-1:0];
        CFG_NULLS_SORT_FIRST: nfirst_r  <= cfg_wdata[0];
        CFG_NULL_KEY_VALUE:   nullkey_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  state_t            state_r, state_nxt;
  logic [SIZE_W-1:0] slot_r, slot_nxt;
  logic [KEY_W-1:0]  prev_key_r, prev_key_nxt;
  logic [SIZE_W-1:0] rank_r, rank_nxt;
  logic [SIZE_W-1:0] dense_r, dense_nxt;
  logic [PCW-1:0]    pc_r, pc_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [SIZE_W-1:0] idx_r, idx_nxt;
  logic              adv_r, adv_nxt;
  logic              lastrow_r, lastrow_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic              ovf_r, ovf_nxt;
  logic              plast_r, plast_nxt;
  logic              fl2_r, fl2_nxt;
  logic [PCW-1:0]    j_r, j_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]  out_pos_r, out_pos_nxt;
  logic [VAL_W-1:0]  out_val_r, out_val_nxt;
  logic              out_ovf_r, out_ovf_nxt;
  logic              out_last_r, out_last_nxt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic             ram_we, ram_re;
  logic [POS_W-1:0] ram_rdata;

  swre_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  swre_ram #(.WIDTH(POS_W), .DEPTH(PEER_BUFFER_DEPTH)) u_peer_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(pc_r[AW-1:0]),
    .wdata(pos_r),
    .re   (ram_re),
    .raddr(j_r[AW-1:0]),
    .rdata(ram_rdata)
  );

  logic [POS_W-1:0]  in_pos;
  logic [KEY_W-1:0]  in_key;
  logic [SIZE_W-1:0] in_size, size_c, rank_c, dense_c, nb_c;
  logic              accept, first, adv_c, last_c, out_free;
  logic [SIZE_W:0]   rnum;

  assign in_pos  = in_tdata[15:0];
  assign in_key  = in_tdata[79:16];
  assign in_size = in_tdata[96:80];

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    if (in_size == '0) size_c = SIZE_W'(1);
    else if ({15'b0, in_size} > 32'(PMAX)) size_c = PMAX_S;
    else size_c = in_size;
  end

  assign first   = (slot_r == '0);
  assign adv_c   = !first && key_before(prev_key_r, in_key, nullkey_r, nfirst_r);
  assign rank_c  = adv_c ? slot_r + SIZE_W'(1) : (first ? SIZE_W'(1) : rank_r);
  assign dense_c = (first ? SIZE_W'(1) : dense_r) + (adv_c ? SIZE_W'(1) : SIZE_W'(0));
  assign last_c  = ({1'b0, slot_r} + 18'd1) >= {1'b0, size_c};
  assign nb_c    = (nbk_r == '0) ? SIZE_W'(1) : nbk_r;
  // fraction numerator: row index at a group change, row index plus one at partition end
  assign rnum    = (state_r == S_C3) ? {1'b0, idx_r} + 18'd1 : {1'b0, idx_r};

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    prev_key_nxt  = prev_key_r;
    rank_nxt      = rank_r;
    dense_nxt     = dense_r;
    pc_nxt        = pc_r;
    pos_nxt       = pos_r;
    size_nxt      = size_r;
    idx_nxt       = idx_r;
    adv_nxt       = adv_r;
    lastrow_nxt   = lastrow_r;
    val_nxt       = val_r;
    ovf_nxt       = ovf_r;
    plast_nxt     = plast_r;
    fl2_nxt       = fl2_r;
    j_nxt         = j_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_pos_nxt   = out_pos_r;
    out_val_nxt   = out_val_r;
    out_ovf_nxt   = out_ovf_r;
    out_last_nxt  = out_last_r;
    div_req       = '0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          pos_nxt      = in_pos;
          size_nxt     = size_c;
          idx_nxt      = slot_r;
          adv_nxt      = adv_c;
          lastrow_nxt  = last_c;
          rank_nxt     = rank_c;
          dense_nxt    = dense_c;
          pc_nxt       = first ? '0 : pc_r;
          prev_key_nxt = in_key;
          slot_nxt     = last_c ? '0 : slot_r + SIZE_W'(1);
          ovf_nxt      = 1'b0;
          plast_nxt    = 1'b1;
          state_nxt    = S_PUT;
          unique case (mode_r)
            MODE_RANK:       val_nxt = VAL_W'(rank_c);
            MODE_DENSE_RANK: val_nxt = VAL_W'(dense_c);
            MODE_PCT_RANK: begin
              if (size_c == SIZE_W'(1)) begin
                val_nxt = '0;
              end else if (rank_c - SIZE_W'(1) >= size_c - SIZE_W'(1)) begin
                val_nxt = ONE_Q32;
              end else begin
                div_req.start = 1'b1;
                div_req.frac  = 1'b1;
                div_req.num   = {1'b0, rank_c - SIZE_W'(1)};
                div_req.den   = size_c - SIZE_W'(1);
                state_nxt     = S_DIV;
              end
            end
            MODE_CUME_DIST: state_nxt = S_C1;
            MODE_NTILE: begin
              // tile size = ceil(size / buckets)
              div_req.start = 1'b1;
              div_req.frac  = 1'b0;
              div_req.num   = {1'b0, size_c} + {1'b0, nb_c} - 18'd1;
              div_req.den   = nb_c;
              state_nxt     = S_NT1;
            end
            default: val_nxt = VAL_W'(slot_r) + VAL_W'(1);
          endcase
        end
      end
      S_PUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = pos_r;
          out_val_nxt   = val_r;
          out_ovf_nxt   = ovf_r;
          out_last_nxt  = plast_r;
          state_nxt     = (mode_r == MODE_CUME_DIST && lastrow_r) ? S_C3 : S_IDLE;
        end
      end
      S_NT1: begin
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          div_req.frac  = 1'b0;
          div_req.num   = {1'b0, idx_r};
          div_req.den   = (div_rsp.quot[SIZE_W-1:0] == '0) ? SIZE_W'(1)
                                                           : div_rsp.quot[SIZE_W-1:0];
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (mode_r == MODE_CUME_DIST) begin
            val_nxt   = {1'b0, div_rsp.quot};
            j_nxt     = '0;
            state_nxt = S_FRD;
          end else begin
            val_nxt   = {1'b0, div_rsp.quot} +
                        ((mode_r == MODE_NTILE) ? VAL_W'(1) : VAL_W'(0));
            state_nxt = S_PUT;
          end
        end
      end
      S_C1, S_C3: begin
        if (state_r == S_C1 && !(adv_r && pc_r != '0)) begin
          state_nxt = S_C2;
        end else begin
          fl2_nxt = (state_r == S_C3);
          j_nxt   = '0;
          if (rnum >= {1'b0, size_r}) begin
            val_nxt   = ONE_Q32;
            state_nxt = S_FRD;
          end else begin
            div_req.start = 1'b1;
            div_req.frac  = 1'b1;
            div_req.num   = rnum;
            div_req.den   = size_r;
            state_nxt     = S_DIV;
          end
        end
      end
      S_C2: begin
        if (pc_r < PCW'(PEER_BUFFER_DEPTH)) begin
          ram_we    = 1'b1;
          pc_nxt    = pc_r + PCW'(1);
          state_nxt = lastrow_r ? S_C3 : S_IDLE;
        end else begin
          // buffer full: row goes out at once flagged
          val_nxt   = '0;
          ovf_nxt   = 1'b1;
          plast_nxt = !lastrow_r;
          state_nxt = S_PUT;
        end
      end
      S_FRD: begin
        ram_re    = 1'b1;
        state_nxt = S_FOUT;
      end
      S_FOUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = ram_rdata;
          out_val_nxt   = val_r;
          out_ovf_nxt   = 1'b0;
          out_last_nxt  = (j_r == pc_r - PCW'(1)) && (fl2_r || !lastrow_r);
          if (j_r == pc_r - PCW'(1)) begin
            pc_nxt    = '0;
            state_nxt = fl2_r ? S_IDLE : S_C2;
          end else begin
            j_nxt     = j_r + PCW'(1);
            state_nxt = S_FRD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_r      <= '0;
      prev_key_r  <= '0;
      rank_r      <= SIZE_W'(1);
      dense_r     <= SIZE_W'(1);
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      prev_key_r  <= prev_key_nxt;
      rank_r      <= rank_nxt;
      dense_r     <= dense_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    size_r     <= size_nxt;
    idx_r      <= idx_nxt;
    adv_r      <= adv_nxt;
    lastrow_r  <= lastrow_nxt;
    val_r      <= val_nxt;
    ovf_r      <= ovf_nxt;
    plast_r    <= plast_nxt;
    fl2_r      <= fl2_nxt;
    j_r        <= j_nxt;
    out_pos_r  <= out_pos_nxt;
    out_val_r  <= out_val_nxt;
    out_ovf_r  <= out_ovf_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_ovf_r, out_val_r, out_pos_r};
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_pc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= PCW'(PEER_BUFFER_DEPTH))
    else $error("peer count above buffer depth");

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_flush_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FOUT) |-> (j_r < pc_r))
    else $error("flush index beyond buffered rows");

  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV || state_r == S_NT1))
    else $error("divider result with no consumer");
`endif
endmodule
`default_nettype wire

// File: verif/tb_top.sv
// self-checking testbench for the sql window rank engine
`default_nettype none
module tb_top;
  import swre_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] MODE_SPARE_6 = 3'd6;
  localparam logic [2:0] MODE_SPARE_7 = 3'd7;
  localparam int PEER_DEPTH = 32;
  localparam int SIZE_CAP   = 65536;
  localparam int SETTLE     = 150;
  localparam logic [63:0] KEY_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] KEY_MAX = 64'h7fff_ffff_ffff_ffff;

  typedef struct {
    logic [15:0] pos;
    logic [32:0] val;
    logic        ovf;
    logic        last;
  } win_result_t;

  logic         clk;
  logic         rst_n;
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [63:0]  cfg_wdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [103:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [55:0]  out_tdata;
  logic         out_tlast;

  sql_window_rank_engine u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // predictor copy of configuration and state
  logic [2:0]  cur_mode;
  logic [16:0] cur_buckets;
  logic        cur_nulls_first;
  logic [63:0] cur_null_key;
  logic [16:0] slot;
  logic [63:0] last_key;
  logic [16:0] rank_now;
  logic [16:0] dense_now;
  logic [15:0] peer_pos [PEER_DEPTH];
  int          peer_cnt;

  win_result_t win_q [$];
  int errors;
  int burst_left;

  function automatic logic orders_before(logic [63:0] a, logic [63:0] b);
    logic an;
    logic bn;
    an = (a == cur_null_key);
    bn = (b == cur_null_key);
    if (an && bn) return 1'b0;
    if (an) return cur_nulls_first;
    if (bn) return !cur_nulls_first;
    return $signed(a) < $signed(b);
  endfunction

  function automatic logic [32:0] frac_q32(logic [63:0] num, logic [63:0] den);
    if (den == 0 || num >= den) return ONE_Q32;
    return 33'((num << 32) / den);
  endfunction

  function automatic void push_result(logic [15:0] pos, logic [32:0] val, logic ovf);
    win_result_t r;
    r.pos = pos; r.val = val; r.ovf = ovf; r.last = 1'b0;
    win_q = {win_q, r};
  endfunction

  function automatic int drain_peers(logic [63:0] num, logic [63:0] den);
    logic [32:0] v;
    int n;
    v = frac_q32(num, den);
    n = peer_cnt;
    for (int j = 0; j < peer_cnt; j++) push_result(peer_pos[j], v, 1'b0);
    peer_cnt = 0;
    return n;
  endfunction

  // expected window values for one accepted row
  function automatic void predict_window(logic [15:0] pos, logic [63:0] key,
                                         logic [16:0] psize);
    logic [63:0] size;
    logic [63:0] idx;
    logic [63:0] nb;
    logic [63:0] tile;
    logic        adv;
    logic        fin;
    int          k;
    k = 0;
    size = 64'(psize);
    idx = 64'(slot);
    if (size == 0) size = 1;
    if (size > SIZE_CAP) size = SIZE_CAP;
    if (idx == 0) begin
      rank_now = 1;
      dense_now = 1;
      peer_cnt = 0;
    end
    adv = (idx != 0) && orders_before(last_key, key);
    if (adv) begin
      rank_now = 17'(idx + 1);
      dense_now = dense_now + 1;
    end
    fin = (idx + 1 >= size);
    case (cur_mode)
      MODE_RANK: begin
        push_result(pos, 33'(rank_now), 1'b0); k++;
      end
      MODE_DENSE_RANK: begin
        push_result(pos, 33'(dense_now), 1'b0); k++;
      end
      MODE_PCT_RANK: begin
        if (size == 1) push_result(pos, '0, 1'b0);
        else push_result(pos, frac_q32(64'(rank_now) - 1, size - 1), 1'b0);
        k++;
      end
      MODE_CUME_DIST: begin
        if (adv && peer_cnt > 0) k += drain_peers(idx, size);
        if (peer_cnt < PEER_DEPTH) begin
          peer_pos[peer_cnt] = pos;
          peer_cnt++;
        end else begin
          push_result(pos, '0, 1'b1); k++;
        end
        if (fin) k += drain_peers(idx + 1, size);
      end
      MODE_NTILE: begin
        nb = (cur_buckets == 0) ? 64'd1 : 64'(cur_buckets);
        tile = (size + nb - 1) / nb;
        if (tile == 0) tile = 1;
        push_result(pos, 33'(idx / tile + 1), 1'b0); k++;
      end
      default: begin
        push_result(pos, 33'(idx + 1), 1'b0); k++;
      end
    endcase
    last_key = key;
    slot = fin ? 17'd0 : 17'(idx + 1);
    if (k > 0) win_q[$].last = 1'b1;
  endfunction

  // result checker
  always @(posedge clk) begin
    win_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (win_q.size() == 0) begin
        $error("unexpected item pos=%0d val=%0h", out_tdata[15:0], out_tdata[48:16]);
        errors++;
      end else begin
        e = win_q.pop_front();
        if (out_tdata[15:0] !== e.pos) begin
          $error("out_position exp %0d got %0d", e.pos, out_tdata[15:0]); errors++;
        end
        if (out_tdata[48:16] !== e.val) begin
          $error("window_value exp %0h got %0h", e.val, out_tdata[48:16]); errors++;
        end
        if (out_tdata[49] !== e.ovf) begin
          $error("group_overflow exp %0b got %0b", e.ovf, out_tdata[49]); errors++;
        end
        if (out_tlast !== e.last) begin
          $error("last_of_run exp %0b got %0b", e.last, out_tlast); errors++;
        end
      end
    end
  end

  // receiver stalls: phases of always-ready, coin flips and long holds
  int stall_phase;
  int phase_left;
  always @(posedge clk) begin
    if (phase_left == 0) begin
      stall_phase <= $urandom_range(0, 2);
      phase_left <= $urandom_range(20, 120);
    end else begin
      phase_left <= phase_left - 1;
    end
    case (stall_phase)
      0: out_tready <= 1'b1;
      1: out_tready <= $urandom_range(0, 1);
      default: out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic send_row(logic [15:0] pos, logic [63:0] key, logic [16:0] psize);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, psize, key, pos};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_window(pos, key, psize);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] data);
    in_tvalid <= 1'b0;
    while (win_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FUNCTION_MODE:    cur_mode = data[2:0];
      CFG_NTILE_BUCKETS:    cur_buckets = data[16:0];
      CFG_NULLS_SORT_FIRST: cur_nulls_first = data[0];
      default:              cur_null_key = data;
    endcase
  endtask

  task automatic test_basic_ranks();
    logic [2:0] modes [5] = '{MODE_ROW_NUMBER, MODE_RANK, MODE_DENSE_RANK,
                              MODE_SPARE_6, MODE_SPARE_7};
    foreach (modes[m]) begin
      write_reg(CFG_FUNCTION_MODE, 64'(modes[m]));
      send_row(16'h0000, KEY_MIN + 1, 17'd5);
      send_row(16'hffff, KEY_MIN + 1, 17'd5);
      send_row(16'h5a5a, 64'd0, 17'd5);
      send_row(16'ha5a5, -64'sd7, 17'd5);  // unsorted key counts as peer
      send_row(16'h0001, KEY_MAX, 17'd5);
    end
  endtask

  task automatic test_null_keys();
    write_reg(CFG_FUNCTION_MODE, 64'(MODE_DENSE_RANK));
    write_reg(CFG_NULL_KEY_VALUE, 64'd42);
    for (int nf = 0; nf < 2; nf++) begin
      write_reg(CFG_NULLS_SORT_FIRST, 64'(nf));
      send_row(16'd1, 64'd42, 17'd4);
      send_row(16'd2, 64'd42, 17'd4);
      send_row(16'd3, 64'd9, 17'd4);
      send_row(16'd4, 64'd42, 17'd4);
    end
    write_reg(CFG_NULL_KEY_VALUE, KEY_MIN);
  endtask

  task automatic test_percent_rank();
    write_reg(CFG_FUNCTION_MODE, 64'(MODE_PCT_RANK));
    send_row(16'd9, 64'd3, 17'd1);
    send_row(16'd9, 64'd3, 17'd0);        // size zero runs as one
    send_row(16'd1, 64'd1, 17'd4);
    send_row(16'd2, 64'd2, 17'd4);
    send_row(16'd3, 64'd3, 17'd2);        // shrunk size ends partition
  endtask

  task automatic test_cume_dist();
    write_reg(CFG_FUNCTION_MODE, 64'(MODE_CUME_DIST));
    send_row(16'd10, 64'd1, 17'd5);
    send_row(16'd11, 64'd1, 17'd5);
    send_row(16'd12, 64'd2, 17'd5);
    send_row(16'd13, 64'd3, 17'd5);
    send_row(16'd14, 64'd3, 17'd5);
    // peer group larger than the buffer
    for (int r = 0; r < 35; r++) send_row(16'(r), 64'd77, 17'd35);
  endtask

  task automatic test_ntile();
    logic [16:0] bk [4] = '{17'd1, 17'd3, 17'd65536, 17'd0};
    write_reg(CFG_FUNCTION_MODE, 64'(MODE_NTILE));
    foreach (bk[b]) begin
      write_reg(CFG_NTILE_BUCKETS, 64'(bk[b]));
      for (int r = 0; r < 3; r++) send_row(16'(r), 64'(r), 17'd7);
      send_row(16'd3, 64'd3, 17'h1ffff);  // clamped size, partition stays open
      send_row(16'd4, 64'd4, 17'd5);      // shrink closes it
    end
    write_reg(CFG_NTILE_BUCKETS, 64'h1ffff);
    send_row(16'd0, 64'd0, 17'd65536);
    send_row(16'd1, 64'd0, 17'd2);
  endtask

  function automatic logic [63:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  task automatic test_random_partitions();
    int sent;
    int rows;
    int psize;
    logic [63:0] key;
    logic [16:0] fsize;
    logic [2:0] modes [6] = '{MODE_ROW_NUMBER, MODE_RANK, MODE_DENSE_RANK,
                              MODE_PCT_RANK, MODE_CUME_DIST, MODE_NTILE};
    sent = 0;
    while (sent < 80) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0: write_reg(CFG_FUNCTION_MODE, 64'(modes[$urandom_range(0, 5)]));
          1: write_reg(CFG_NTILE_BUCKETS, 64'($urandom_range(1, 9)));
          2: write_reg(CFG_NULLS_SORT_FIRST, 64'($urandom_range(0, 1)));
          default: write_reg(CFG_NULL_KEY_VALUE,
                             $urandom_range(0, 1) ? rand_key() : 64'($urandom_range(0, 6)));
        endcase
      end
      psize = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      rows = psize;
      key = $urandom_range(0, 1) ? rand_key() : 64'($urandom_range(0, 3));
      for (int r = 0; r < rows; r++) begin
        fsize = 17'(psize);
        if ($urandom_range(0, 15) == 0) fsize = 17'($urandom());
        case ($urandom_range(0, 9))
          0: key = cur_null_key;
          1: key = rand_key();
          2, 3, 4: key = key + 1;
          default: ;                       // peer of the previous row
        endcase
        send_row(16'($urandom()), key, fsize);
        sent++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    errors = 0;
    burst_left = 0;
    cur_mode = MODE_ROW_NUMBER;
    cur_buckets = 17'd1;
    cur_nulls_first = 1'b0;
    cur_null_key = KEY_MIN;
    slot = '0;
    last_key = '0;
    rank_now = 17'd1;
    dense_now = 17'd1;
    peer_cnt = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_ranks();
    test_null_keys();
    test_percent_rank();
    test_cume_dist();
    test_ntile();
    test_random_partitions();
    in_tvalid <= 1'b0;
    while (win_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire
